// ===== hw/rtl/rrtr_pkg.sv =====
// ----------------------------------------------------------------------------
// RIP-relative target resolver package
// Shared word types, mode codes, opcode constants and byte classifiers.
// ----------------------------------------------------------------------------
package rrtr_pkg;

	// Mode codes carried in the action field.
	localparam logic [2:0] MODE_JMP  = 3'd0;
	localparam logic [2:0] MODE_CALL = 3'd1;
	localparam logic [2:0] MODE_MOV  = 3'd2;
	localparam logic [2:0] MODE_LEA  = 3'd3;
	localparam logic [2:0] MODE_SIMD = 3'd4;

	// Opcode and prefix bytes.
	localparam logic [7:0] OPC_JMP_REL32  = 8'hE9;
	localparam logic [7:0] OPC_CALL_REL32 = 8'hE8;
	localparam logic [7:0] OPC_MOV_LOAD   = 8'h8B;
	localparam logic [7:0] OPC_MOV_STORE  = 8'h89;
	localparam logic [7:0] OPC_LEA        = 8'h8D;
	localparam logic [7:0] OPC_ESCAPE     = 8'h0F;
	localparam logic [7:0] PFX_OPSIZE     = 8'h66;
	localparam logic [7:0] PFX_REPNE      = 8'hF2;
	localparam logic [7:0] PFX_REP        = 8'hF3;
	localparam logic [7:0] REX_BASE       = 8'h40;
	localparam logic [7:0] MODRM_RIP_MASK = 8'hC7;
	localparam logic [7:0] MODRM_RIP_VAL  = 8'h05;

	localparam int unsigned WIN_BYTES = 12;
	localparam int unsigned NUM_SIMD_OPS = 16;
	localparam int unsigned MAX_PREFIXES = 4;

	// Second opcode bytes accepted after the 0F escape.
	localparam logic [7:0] SIMD_OPS [NUM_SIMD_OPS] = '{
		8'h10, 8'h11, 8'h28, 8'h29, 8'h6F, 8'h7F, 8'h2E, 8'h2F,
		8'h51, 8'h52, 8'h58, 8'h59, 8'h5C, 8'h5D, 8'h5E, 8'h5F
	};

	typedef logic [3:0] win_idx_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] instruction_address;
		logic [63:0] code_bytes_low;
		logic [31:0] code_bytes_high;
	} cmd_word_t;

	typedef struct packed {
		logic [63:0] target_address;
		logic        matched;
	} rsp_word_t;

	// Decoder status seen by the top level.
	typedef struct packed {
		logic     matched;
		win_idx_t disp_pos;
	} dec_info_t;

	function automatic logic is_rex(input logic [7:0] b);
		return b[7:4] == REX_BASE[7:4];
	endfunction

	function automatic logic is_rip_modrm(input logic [7:0] b);
		return (b & MODRM_RIP_MASK) == MODRM_RIP_VAL;
	endfunction

	function automatic logic is_simd_prefix(input logic [7:0] b);
		return (b == PFX_OPSIZE) || (b == PFX_REPNE) || (b == PFX_REP);
	endfunction

	function automatic logic is_simd_op(input logic [7:0] b);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < NUM_SIMD_OPS; k++) begin
			if (SIMD_OPS[k] == b) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// ===== hw/rtl/rrtr_if.sv =====
// ----------------------------------------------------------------------------
// RIP-relative target resolver channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface rrtr_cmd_if;
	logic                 valid;
	logic                 ready;
	rrtr_pkg::cmd_word_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rrtr_rsp_if;
	logic                 valid;
	logic                 ready;
	rrtr_pkg::rsp_word_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/rrtr_decode.sv =====
// ----------------------------------------------------------------------------
// RIP-relative operand decoder
// Matches the encoding for the selected mode and forms the target address.
// ----------------------------------------------------------------------------
module rrtr_decode (
	input  rrtr_pkg::cmd_word_t cmd,
	output rrtr_pkg::rsp_word_t rsp,
	output rrtr_pkg::dec_info_t info
);

	logic [7:0]         win [rrtr_pkg::WIN_BYTES];
	logic               pf0, pf1, pf2, pf3;
	rrtr_pkg::win_idx_t pfx_end;
	rrtr_pkg::win_idx_t simd_esc;
	rrtr_pkg::win_idx_t mov_op;
	rrtr_pkg::win_idx_t pos;
	logic               ok;
	logic [31:0]        disp;
	logic [3:0]         ins_len;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			win[i] = cmd.code_bytes_low[8*i +: 8];
		end
		for (int i = 0; i < 4; i++) begin
			win[8+i] = cmd.code_bytes_high[8*i +: 8];
		end
	end

	// The simd prefix run stops at the first non-prefix or after four bytes.
	assign pf0 = rrtr_pkg::is_simd_prefix(win[0]);
	assign pf1 = pf0 & rrtr_pkg::is_simd_prefix(win[1]);
	assign pf2 = pf1 & rrtr_pkg::is_simd_prefix(win[2]);
	assign pf3 = pf2 & rrtr_pkg::is_simd_prefix(win[3]);

	always_comb begin
		if (pf3) begin
			pfx_end = 4'd4;
		end else if (pf2) begin
			pfx_end = 4'd3;
		end else if (pf1) begin
			pfx_end = 4'd2;
		end else if (pf0) begin
			pfx_end = 4'd1;
		end else begin
			pfx_end = 4'd0;
		end
	end

	assign simd_esc = pfx_end + {3'd0, rrtr_pkg::is_rex(win[pfx_end])};
	assign mov_op   = {3'd0, rrtr_pkg::is_rex(win[0])};

	always_comb begin
		ok  = 1'b0;
		pos = 4'd0;
		unique case (cmd.action)
			rrtr_pkg::MODE_JMP: begin
				ok  = win[0] == rrtr_pkg::OPC_JMP_REL32;
				pos = 4'd1;
			end
			rrtr_pkg::MODE_CALL: begin
				ok  = win[0] == rrtr_pkg::OPC_CALL_REL32;
				pos = 4'd1;
			end
			rrtr_pkg::MODE_MOV: begin
				ok  = ((win[mov_op] == rrtr_pkg::OPC_MOV_LOAD) ||
				       (win[mov_op] == rrtr_pkg::OPC_MOV_STORE)) &&
				      rrtr_pkg::is_rip_modrm(win[mov_op + 4'd1]);
				pos = mov_op + 4'd2;
			end
			rrtr_pkg::MODE_LEA: begin
				ok  = (win[mov_op] == rrtr_pkg::OPC_LEA) &&
				      rrtr_pkg::is_rip_modrm(win[mov_op + 4'd1]);
				pos = mov_op + 4'd2;
			end
			rrtr_pkg::MODE_SIMD: begin
				ok  = (win[simd_esc] == rrtr_pkg::OPC_ESCAPE) &&
				      rrtr_pkg::is_simd_op(win[simd_esc + 4'd1]) &&
				      rrtr_pkg::is_rip_modrm(win[simd_esc + 4'd2]);
				pos = simd_esc + 4'd3;
			end
			default: begin
				ok  = 1'b0;
				pos = 4'd0;
			end
		endcase
	end

	assign disp    = {win[pos + 4'd3], win[pos + 4'd2], win[pos + 4'd1], win[pos]};
	assign ins_len = pos + 4'd4;

	always_comb begin
		rsp.matched = ok;
		if (ok) begin
			rsp.target_address = cmd.instruction_address
				+ {{32{disp[31]}}, disp} + {60'd0, ins_len};
		end else begin
			rsp.target_address = cmd.instruction_address;
		end
	end

	assign info.matched  = ok;
	assign info.disp_pos = pos;

endmodule

// ===== hw/rtl/rip_relative_target_resolver_top.sv =====
// ----------------------------------------------------------------------------
// RIP-relative target resolver
// Resolves the target of a jmp, call, mov, lea or simd RIP-relative operand.
// ----------------------------------------------------------------------------
// The block takes one command word per cycle unless stalled and returns one
// result word for each, in order. A command accepted at a clock edge is
// captured in the input register, decoded and added in the single stage of
// logic behind it, and its result then loads into the result register, which
// drives the result channel; the sustained rate is one word per cycle. That
// rate is set by the one decode stage, whose longest path is the byte select
// of the displacement followed by the 64-bit address add. A finished result
// that is not taken holds in the result register while the input register
// still takes one more command; the input side stalls only when both are full
// and the result is not taken. Unmatched encodings and unused mode codes give
// the instruction address back unchanged with matched low.
// ----------------------------------------------------------------------------
module rip_relative_target_resolver_top (
	input logic             clk,
	input logic             arst_n,
	rrtr_cmd_if.sink        cmd,
	rrtr_rsp_if.source      rsp
);

	// Input register.
	logic                vld_s1;
	rrtr_pkg::cmd_word_t cmd_s1;

	// Result register.
	logic                vld_s2;
	rrtr_pkg::rsp_word_t rsp_s2;

	// Decode of the word held in the input register.
	rrtr_pkg::rsp_word_t dec_rsp;
	rrtr_pkg::dec_info_t dec_info;

	logic adv_s2;
	logic adv_s1;

	// The result register can load when it is empty or being drained.
	assign adv_s2    = !vld_s2 || rsp.ready;
	// The input register can load when it is empty or moving forward.
	assign adv_s1    = !vld_s1 || adv_s2;
	assign cmd.ready = adv_s1;

	rrtr_decode u_decode (
		.cmd  (cmd_s1),
		.rsp  (dec_rsp),
		.info (dec_info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= cmd.valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Payload registers load without reset; the valid bits qualify them.
	always_ff @(posedge clk) begin
		if (adv_s1 && cmd.valid) begin
			cmd_s1 <= cmd.data;
		end
		if (adv_s2 && vld_s1) begin
			rsp_s2 <= dec_rsp;
		end
	end

	assign rsp.valid = vld_s2;
	assign rsp.data  = rsp_s2;

	// Unused mode codes never match.
	a_unused_mode_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && (cmd_s1.action > rrtr_pkg::MODE_SIMD) |-> !dec_info.matched)
		else $error("unused mode code decoded as a match");

	// A matched jmp or call has its displacement right after the opcode.
	a_rel_disp_pos: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && dec_info.matched &&
		((cmd_s1.action == rrtr_pkg::MODE_JMP) || (cmd_s1.action == rrtr_pkg::MODE_CALL))
		|-> dec_info.disp_pos == 4'd1)
		else $error("relative branch displacement misplaced");

	// The displacement always lies inside the 12-byte window.
	a_disp_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && dec_info.matched |-> dec_info.disp_pos <= 4'd8)
		else $error("displacement runs past the code window");

	// A mismatch returns the instruction address unchanged.
	a_mismatch_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !dec_info.matched |->
		dec_rsp.target_address == cmd_s1.instruction_address)
		else $error("unmatched word altered the address");

	// With both registers full and the result not taken, no command enters.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 && !rsp.ready |-> !cmd.ready)
		else $error("command accepted while the pipeline is full");

	// A result that waits is still there in the next cycle.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !rsp.ready |=> vld_s2 && $stable(rsp_s2))
		else $error("waiting result was dropped or changed");

endmodule

// ===== dv/tb_rip_relative_target_resolver_top.sv =====
// ----------------------------------------------------------------------------
// RIP-relative target resolver testbench
// Drives command words through a table of directed encodings and then
// through random, mostly well-formed jmp, call, mov, lea and simd windows.
// Every result word is checked against an in-bench decoder or a fixed row's value.
// ----------------------------------------------------------------------------
module tb_rip_relative_target_resolver_top;
	import rrtr_pkg::*;

	// Mode codes that the block must treat as unmatched.
	localparam logic [2:0] MODE_RSVD5 = 3'd5;
	localparam logic [2:0] MODE_RSVD6 = 3'd6;
	localparam logic [2:0] MODE_RSVD7 = 3'd7;

	localparam int unsigned RANDOM_WORDS = 1850;
	localparam int unsigned DRAIN_CYCLES = 8;

	// Second opcode bytes accepted after the 0F escape, kept apart from the
	// package list so that a wrong entry there shows up as a mismatch.
	localparam logic [7:0] SSE_OPCODES [16] = '{
		8'h10, 8'h11, 8'h28, 8'h29, 8'h6F, 8'h7F, 8'h2E, 8'h2F,
		8'h51, 8'h52, 8'h58, 8'h59, 8'h5C, 8'h5D, 8'h5E, 8'h5F
	};

	// One directed row. The code window is written byte 0 first, so the
	// literals read in instruction order; displacements are little endian.
	// Where fixed is set the expected result is typed in the row itself,
	// otherwise the decoder below supplies it.
	typedef struct packed {
		logic [2:0]       mode;
		logic [63:0]      addr;
		logic [0:11][7:0] code;
		logic             fixed;
		logic [63:0]      want_target;
		logic             want_matched;
	} dir_row_t;

	localparam int unsigned NUM_DIRECTED = 25;
	localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
		// jmp and call: zero displacement, largest positive displacement with
		// the address wrapping past the top, most negative displacement.
		'{MODE_JMP,   64'h0,                  96'hE9000000_00000000_00000000,
			1'b1, 64'h5,                  1'b1},
		'{MODE_JMP,   64'hFFFF_FFFF_FFFF_FFFF, 96'hE9FFFFFF_7FAAAAAA_AAAAAAAA,
			1'b1, 64'h8000_0003,          1'b1},
		'{MODE_CALL,  64'h8000_0000,          96'hE8000000_80555555_55555555,
			1'b1, 64'h5,                  1'b1},
		// The other relative opcode under each mode does not match.
		'{MODE_JMP,   64'h0123_4567_89AB_CDEF, 96'hE8123456_78000000_00000000,
			1'b1, 64'h0123_4567_89AB_CDEF, 1'b0},
		'{MODE_CALL,  64'hFEDC_BA98_7654_3210, 96'hE9FFFFFF_FF000000_00000000,
			1'b1, 64'hFEDC_BA98_7654_3210, 1'b0},
		// mov and lea with and without REX, both mov directions.
		'{MODE_MOV,   64'h1000,               96'h8B057856_34120000_00000000,
			1'b0, 64'h0,                  1'b0},
		'{MODE_MOV,   64'h0000_7FF6_1234_0000, 96'h48893DF0_FFFFFFC3_90909090,
			1'b0, 64'h0,                  1'b0},
		'{MODE_MOV,   64'hFFFF_FFFF_FFFF_FFFF, 96'h4F8B0501_00000000_00000000,
			1'b0, 64'h0,                  1'b0},
		'{MODE_LEA,   64'h8000_0000_0000_0000, 96'h8D050000_00800000_00000000,
			1'b0, 64'h0,                  1'b0},
		'{MODE_LEA,   64'h0000_0001_0000_0000, 96'h4C8D0D10_20304000_00000000,
			1'b0, 64'h0,                  1'b0},
		// ModRM with a displacement byte, opcode from the wrong mode, SIB form,
		// and a second REX byte sitting in the opcode slot.
		'{MODE_MOV,   64'h2000,               96'h8B451234_56780000_00000000,
			1'b1, 64'h2000,               1'b0},
		'{MODE_LEA,   64'h3000,               96'h8B051234_56780000_00000000,
			1'b1, 64'h3000,               1'b0},
		'{MODE_MOV,   64'h4000,               96'h8B042512_34567800_00000000,
			1'b1, 64'h4000,               1'b0},
		'{MODE_MOV,   64'h5000,               96'h40408B05_12345678_00000000,
			1'b1, 64'h5000,               1'b0},
		// simd: bare, one prefix, prefix plus REX, and the longest form with
		// four prefixes and REX that puts the displacement in the last bytes.
		'{MODE_SIMD,  64'h6000,               96'h0F100504_03020100_00000000,
			1'b0, 64'h0,                  1'b0},
		'{MODE_SIMD,  64'h10,                 96'h660F6F05_FCFFFFFF_00000000,
			1'b0, 64'h0,                  1'b0},
		'{MODE_SIMD,  64'hFFFF_FFFF_FFFF_FFF0, 96'hF3480F7F_0D000100_00000000,
			1'b0, 64'h0,                  1'b0},
		'{MODE_SIMD,  64'h7FFF_FFFF_FFFF_FFFF, 96'h66F2F366_4F0F5F3D_11223344,
			1'b0, 64'h0,                  1'b0},
		// A fifth prefix lands on the escape position and fails.
		'{MODE_SIMD,  64'h7000,               96'h66666666_660F2805_00000000,
			1'b1, 64'h7000,               1'b0},
		// Unlisted opcode, missing escape, register-direct ModRM.
		'{MODE_SIMD,  64'h8000,               96'h0F120500_00000000_00000000,
			1'b1, 64'h8000,               1'b0},
		'{MODE_SIMD,  64'h9000,               96'h66100500_00000000_00000000,
			1'b1, 64'h9000,               1'b0},
		'{MODE_SIMD,  64'hA000,               96'h0F28C500_00000000_00000000,
			1'b1, 64'hA000,               1'b0},
		// Unused mode codes never match, even on a valid encoding.
		'{MODE_RSVD5, 64'hB000,               96'hE9000000_00000000_00000000,
			1'b1, 64'hB000,               1'b0},
		'{MODE_RSVD7, 64'hFFFF_FFFF_FFFF_FFFF, 96'hFFFFFFFF_FFFFFFFF_FFFFFFFF,
			1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
		'{MODE_RSVD6, 64'hC000,               96'h8B050000_00000000_00000000,
			1'b1, 64'hC000,               1'b0}
	};

	logic clk;
	logic arst_n;

	rrtr_cmd_if cmd_ch();
	rrtr_rsp_if rsp_ch();

	rip_relative_target_resolver_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Results still owed by the block, oldest first.
	rsp_word_t pending_targets [$];

	int unsigned fail_count;
	int unsigned mode_words [8];
	int unsigned matched_words;
	int unsigned passed_words;

	// When set, neither side inserts gaps, so back-to-back traffic is seen.
	bit calm;

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// In-bench decoder
	// ------------------------------------------------------------------------

	function automatic logic [7:0] win_byte(logic [95:0] win, int unsigned idx);
		return (idx < WIN_BYTES) ? win[8*idx +: 8] : 8'h00;
	endfunction

	function automatic logic rex_prefix(logic [7:0] b);
		return (b >= REX_BASE) && (b <= (REX_BASE | 8'h0F));
	endfunction

	// ModRM that selects disp32 off the instruction pointer: mod 00, r/m 101.
	function automatic logic rip_operand(logic [7:0] b);
		return (b[7:6] == 2'b00) && (b[2:0] == 3'b101);
	endfunction

	// Works out the result word for one command word. pos walks the window
	// and, on a match, ends on the first displacement byte.
	function automatic rsp_word_t resolve_target(cmd_word_t w);
		logic [95:0] win;
		logic [7:0]  b;
		logic [31:0] disp;
		int unsigned pos;
		logic        ok;
		rsp_word_t   r;

		win = {w.code_bytes_high, w.code_bytes_low};
		pos = 0;
		ok = 1'b0;
		case (w.action)
			MODE_JMP, MODE_CALL: begin
				b = win_byte(win, 0);
				if (b == ((w.action == MODE_JMP) ? OPC_JMP_REL32 : OPC_CALL_REL32)) begin
					pos = 1;
					ok = 1'b1;
				end
			end
			MODE_MOV, MODE_LEA: begin
				if (rex_prefix(win_byte(win, 0))) begin
					pos = 1;
				end
				b = win_byte(win, pos);
				if (w.action == MODE_MOV) begin
					ok = (b == OPC_MOV_LOAD) || (b == OPC_MOV_STORE);
				end else begin
					ok = (b == OPC_LEA);
				end
				pos++;
				ok = ok && rip_operand(win_byte(win, pos));
				pos++;
			end
			MODE_SIMD: begin
				for (int k = 0; k < MAX_PREFIXES; k++) begin
					b = win_byte(win, pos);
					if (b != PFX_OPSIZE && b != PFX_REPNE && b != PFX_REP) begin
						break;
					end
					pos++;
				end
				if (rex_prefix(win_byte(win, pos))) begin
					pos++;
				end
				if (win_byte(win, pos) == OPC_ESCAPE) begin
					b = win_byte(win, pos + 1);
					foreach (SSE_OPCODES[k]) begin
						if (SSE_OPCODES[k] == b) begin
							ok = 1'b1;
						end
					end
					pos += 2;
					ok = ok && rip_operand(win_byte(win, pos));
					pos++;
				end
			end
			default: begin
			end
		endcase

		if (ok) begin
			disp = win[8*pos +: 32];
			r.target_address = w.instruction_address + {{32{disp[31]}}, disp} + 64'(pos + 4);
			r.matched = 1'b1;
		end else begin
			r.target_address = w.instruction_address;
			r.matched = 1'b0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic cmd_word_t build_cmd(logic [2:0] mode, logic [63:0] addr,
			logic [0:11][7:0] code);
		cmd_word_t w;

		w.action = mode;
		w.instruction_address = addr;
		for (int i = 0; i < 8; i++) begin
			w.code_bytes_low[8*i +: 8] = code[i];
		end
		for (int i = 0; i < 4; i++) begin
			w.code_bytes_high[8*i +: 8] = code[8 + i];
		end
		return w;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;

		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_prefix();
		case ($urandom_range(0, 2))
			0: begin
				return PFX_OPSIZE;
			end
			1: begin
				return PFX_REPNE;
			end
			default: begin
				return PFX_REP;
			end
		endcase
	endfunction

	// Random command word. Most words are well-formed encodings for their
	// mode with random registers, displacement and trailing bytes, so that
	// the decoder gets past its first checks. A share of them is broken by
	// one overwritten byte or a wrong mode, some carry a run of five simd
	// prefixes, and the rest is plain noise over all eight mode codes.
	function automatic cmd_word_t random_cmd();
		logic [0:11][7:0] code;
		logic [2:0]       mode;
		logic [63:0]      addr;
		int unsigned      style;
		int unsigned      p;

		for (int i = 0; i < 12; i++) begin
			code[i] = 8'($urandom);
		end
		mode = 3'($urandom_range(MODE_JMP, MODE_SIMD));
		style = $urandom_range(0, 99);
		p = 0;

		if (style < 80) begin
			case (mode)
				MODE_JMP: begin
					code[0] = OPC_JMP_REL32;
					p = 1;
				end
				MODE_CALL: begin
					code[0] = OPC_CALL_REL32;
					p = 1;
				end
				MODE_MOV, MODE_LEA: begin
					if ($urandom_range(0, 1)) begin
						code[p] = REX_BASE | 8'($urandom_range(0, 15));
						p++;
					end
					if (mode == MODE_LEA) begin
						code[p] = OPC_LEA;
					end else begin
						code[p] = $urandom_range(0, 1) ? OPC_MOV_LOAD : OPC_MOV_STORE;
					end
					p++;
					code[p] = {2'b00, 3'($urandom), 3'b101};
					p++;
				end
				default: begin
					repeat ($urandom_range(0, MAX_PREFIXES)) begin
						code[p] = pick_prefix();
						p++;
					end
					if ($urandom_range(0, 1)) begin
						code[p] = REX_BASE | 8'($urandom_range(0, 15));
						p++;
					end
					code[p] = OPC_ESCAPE;
					code[p + 1] = SSE_OPCODES[$urandom_range(0, 15)];
					code[p + 2] = {2'b00, 3'($urandom), 3'b101};
					p += 3;
				end
			endcase
			if (style >= 65) begin
				if ($urandom_range(0, 1)) begin
					code[$urandom_range(0, p - 1)] = 8'($urandom);
				end else begin
					mode = 3'($urandom_range(MODE_JMP, MODE_RSVD7));
				end
			end
		end else if (style < 85) begin
			// Five prefixes in a row, followed by a plausible tail.
			mode = MODE_SIMD;
			for (int i = 0; i < 5; i++) begin
				code[i] = pick_prefix();
			end
			code[5] = OPC_ESCAPE;
			code[6] = SSE_OPCODES[$urandom_range(0, 15)];
			code[7] = {2'b00, 3'($urandom), 3'b101};
		end else begin
			mode = 3'($urandom_range(MODE_JMP, MODE_RSVD7));
		end

		case ($urandom_range(0, 3))
			0: begin
				addr = 64'($urandom_range(0, 255));
			end
			1: begin
				addr = ~64'($urandom_range(0, 255));
			end
			default: begin
				addr = {$urandom, $urandom};
			end
		endcase
		return build_cmd(mode, addr, code);
	endfunction

	// Offers one command word and returns at the edge that accepts it. The
	// expected result is queued as the word goes out; it cannot come back
	// before the word is taken, and words are taken in order.
	task automatic send_cmd(cmd_word_t w, rsp_word_t want);
		pending_targets.push_back(want);
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= w;
		@(posedge clk);
		while (!cmd_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Leaves valid high for a back-to-back word, or drops it for a gap.
	task automatic idle_sender();
		int unsigned gap;

		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------
	initial begin
		cmd_word_t w;

		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		calm = 1'b0;

		repeat (11) @(posedge clk);
		// Release reset away from the rising edge so that it cannot race the
		// first clocked update inside the block.
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			w = build_cmd(DIRECTED[i].mode, DIRECTED[i].addr, DIRECTED[i].code);
			if (DIRECTED[i].fixed) begin
				send_cmd(w, '{DIRECTED[i].want_target, DIRECTED[i].want_matched});
			end else begin
				send_cmd(w, resolve_target(w));
			end
			idle_sender();
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// Every third stretch of 200 words runs with no gaps on either side.
			calm = ((i / 200) % 3) == 1;
			// Twice in the run the sender holds back until the block is empty.
			if (i == 600 || i == 1300) begin
				cmd_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_targets.size() != 0) begin
					@(posedge clk);
				end
			end
			w = random_cmd();
			send_cmd(w, resolve_target(w));
			idle_sender();
		end
		calm = 1'b0;

		// Drain: wait for every owed result, then keep watching to catch
		// any stray word the block might still put out.
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_targets.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Resolved %0d words: %0d jmp, %0d call, %0d mov, %0d lea, %0d simd, %0d unused mode.",
			mode_words[MODE_JMP] + mode_words[MODE_CALL] + mode_words[MODE_MOV]
			+ mode_words[MODE_LEA] + mode_words[MODE_SIMD] + mode_words[MODE_RSVD5]
			+ mode_words[MODE_RSVD6] + mode_words[MODE_RSVD7],
			mode_words[MODE_JMP], mode_words[MODE_CALL], mode_words[MODE_MOV],
			mode_words[MODE_LEA], mode_words[MODE_SIMD],
			mode_words[MODE_RSVD5] + mode_words[MODE_RSVD6] + mode_words[MODE_RSVD7]);
		$display("%0d encodings resolved to a target, %0d passed through unmatched, %0d errors.",
			matched_words, passed_words, fail_count);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls on the result channel, none in calm stretches.
	// ------------------------------------------------------------------------
	initial begin
		int unsigned stall_left;

		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Checker. Handshakes are sampled at the rising edge, before any of the
	// updates made at that edge take effect.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_word_t want;

		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				mode_words[cmd_ch.data.action]++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_targets.size() == 0) begin
					$error("result word with no command outstanding: target_address %h matched %b",
						rsp_ch.data.target_address, rsp_ch.data.matched);
					fail_count++;
				end else begin
					want = pending_targets.pop_front();
					if (rsp_ch.data.matched) begin
						matched_words++;
					end else begin
						passed_words++;
					end
					if (rsp_ch.data.target_address !== want.target_address) begin
						$error("target_address: expected %h, got %h",
							want.target_address, rsp_ch.data.target_address);
						fail_count++;
					end
					if (rsp_ch.data.matched !== want.matched) begin
						$error("matched: expected %b, got %b", want.matched, rsp_ch.data.matched);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog, far beyond the slowest passing run.
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
